// ===== rtl/bspr_pkg.sv =====
// ----------------------------------------------------------------------------
// bspr_pkg
// Types and fixed widths for the bit stream period run detector: the input
// beat, the result beat and the configuration register.
// ----------------------------------------------------------------------------
package bspr_pkg;

    localparam int CFG_W    = 7;
    localparam int PERIOD_W = 7;
    localparam int OUT_W    = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic data_bit;
        logic end_of_stream;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0]    start_position;
        logic [PERIOD_W-1:0] period;
        logic [OUT_W-1:0]    block_length;
        logic                last_of_item;
    } result_t;

endpackage

// ===== rtl/bit_stream_period_run_detector.sv =====
// ----------------------------------------------------------------------------
// bit_stream_period_run_detector
// Compares each incoming bit with the bit one period back for every active
// period, keeps a saturating run counter per period and reports finished
// repeating blocks as (start, period, length).
// ----------------------------------------------------------------------------
//  channel  | dir | signals                            | beat
//  item     | in  | item_valid, item_ready, item       | one stream bit + end mark
//  result   | out | result_valid, result_ready, result | one reported block
//  cfg      | in  | cfg_valid, cfg_ready, cfg_data     | periods_in_use write
//
//  A bit passes through accept, a walk over the active periods (one shared unit, one
//  period per cycle unless a report stalls it, behind a registered counter read) and a
//  finish step. end_of_stream adds a flush walk over the same periods.
//  item_ready is high only in idle. A report that finds the output register and
//  the waiting slot both full holds the walk; the finish step waits for the output.
//  Reset is asynchronous and clears control state and the counter valid bits.
// ----------------------------------------------------------------------------
module bit_stream_period_run_detector #(
    parameter int MAX_PERIOD = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  bspr_pkg::item_t        item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output bspr_pkg::result_t      result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [bspr_pkg::CFG_W-1:0] cfg_data
);
    import bspr_pkg::*;

    localparam int IDX_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int CW    = $clog2(MAX_PERIOD + 2);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_FLUSH,
        ST_FIN
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        cfg_reg;
    logic [MAX_PERIOD-1:0]   hist_reg;
    logic [COUNT_BITS-1:0]   pos_reg;
    logic [COUNT_BITS-1:0]   here_reg;
    logic [CW-1:0]           active_reg;
    logic                    bit_reg;
    logic                    eos_reg;
    logic [CW-1:0]           rd_p_reg;
    logic                    ex_valid_reg;
    logic [CW-1:0]           ex_p_reg;
    logic [MAX_PERIOD-1:0]   cnt_vld_reg;
    logic [COUNT_BITS-1:0]   rdata_reg;

    logic                    pend_valid_reg;
    logic [COUNT_BITS:0]     pend_span_reg;
    logic [COUNT_BITS-1:0]   pend_at_reg;
    logic [CW-1:0]           pend_p_reg;

    logic                    out_valid_reg;
    result_t                 out_reg;

    logic [COUNT_BITS-1:0]   cnt_mem [MAX_PERIOD];

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]      lim;
    logic [CW-1:0]         active_new;
    logic                  in_pass;
    logic                  rd_go;
    logic [IDX_W-1:0]      rd_idx;
    logic [IDX_W-1:0]      ex_idx;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic                  match;
    logic                  report;
    logic [COUNT_BITS:0]   span;
    logic [COUNT_BITS-1:0] at_pos;
    logic                  out_free;
    logic                  stall;
    logic                  adv;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  pass_done;
    logic                  out_load;
    result_t               pend_res;

    always_comb
    begin
        if (cfg_reg == '0)
            lim = CFG_W'(1);
        else if ({1'b0, cfg_reg} > (CFG_W+1)'(MAX_PERIOD))
            lim = CFG_W'(MAX_PERIOD);
        else
            lim = cfg_reg;

        if (pos_reg < COUNT_BITS'(lim))
            active_new = CW'(pos_reg);
        else
            active_new = CW'(lim);
    end

    assign in_pass = (state_reg == ST_CMP) || (state_reg == ST_FLUSH);
    assign rd_go   = in_pass && (rd_p_reg <= active_reg) && (rd_p_reg != '0);
    assign rd_idx  = IDX_W'(rd_p_reg - CW'(1));
    assign ex_idx  = IDX_W'(ex_p_reg - CW'(1));

    assign cnt_cur = cnt_vld_reg[ex_idx] ? rdata_reg : '0;
    assign match   = (hist_reg[ex_idx] == bit_reg);
    assign report  = ex_valid_reg && ((state_reg == ST_FLUSH) || !match)
                     && (cnt_cur >= COUNT_BITS'(ex_p_reg));
    assign span    = {1'b0, cnt_cur} + (COUNT_BITS+1)'(ex_p_reg);
    assign at_pos  = (state_reg == ST_FLUSH) ? pos_reg : here_reg;

    assign out_free = !out_valid_reg || result_ready;
    assign stall    = report && pend_valid_reg && !out_free;
    assign adv      = in_pass && !stall;
    assign pass_done = in_pass && !rd_go && !ex_valid_reg;

    // the waiting report moves to the output when a new one arrives or at finish
    assign out_load = (adv && report && pend_valid_reg)
                   || ((state_reg == ST_FIN) && pend_valid_reg && out_free);

    // counter write-back, compare pass only; the flush clears all valid bits
    assign wr_en   = adv && ex_valid_reg && (state_reg == ST_CMP);
    assign wr_data = !match ? '0
                   : (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

    // waiting report -> result beat
    always_comb
    begin
        pend_res = '0;
        if (pend_span_reg > {1'b0, pend_at_reg})
            pend_res.start_position = '0;
        else
            pend_res.start_position = OUT_W'(pend_at_reg - pend_span_reg[COUNT_BITS-1:0]);
        pend_res.period = PERIOD_W'(pend_p_reg);
        if (pend_span_reg[COUNT_BITS])
            pend_res.block_length = OUT_W'(COUNT_MAX);
        else
            pend_res.block_length = OUT_W'(pend_span_reg[COUNT_BITS-1:0]);
        pend_res.last_of_item = (state_reg == ST_FIN);
    end

    // ------------------------------------------------------------------
    // counter memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            cnt_mem[ex_idx] <= wr_data;
        if (adv && rd_go)
            rdata_reg <= cnt_mem[rd_idx];
    end

    // ------------------------------------------------------------------
    // sequencer, state and outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cfg_reg        <= CFG_RESET;
            hist_reg       <= '0;
            pos_reg        <= '0;
            here_reg       <= '0;
            active_reg     <= '0;
            bit_reg        <= 1'b0;
            eos_reg        <= 1'b0;
            rd_p_reg       <= '0;
            ex_valid_reg   <= 1'b0;
            ex_p_reg       <= '0;
            cnt_vld_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_span_reg  <= '0;
            pend_at_reg    <= '0;
            pend_p_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
                cfg_reg <= cfg_data;

            if (out_load)
            begin
                out_reg       <= pend_res;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        bit_reg    <= item.data_bit;
                        eos_reg    <= item.end_of_stream;
                        here_reg   <= pos_reg;
                        active_reg <= active_new;
                        if (pos_reg != COUNT_MAX)
                            pos_reg <= pos_reg + COUNT_BITS'(1);
                        rd_p_reg   <= CW'(1);
                        state_reg  <= ST_CMP;
                    end
                end

                ST_CMP, ST_FLUSH:
                begin
                    if (adv)
                    begin
                        ex_valid_reg <= rd_go;
                        ex_p_reg     <= rd_p_reg;
                        if (rd_go)
                            rd_p_reg <= rd_p_reg + CW'(1);
                        if (wr_en)
                            cnt_vld_reg[ex_idx] <= 1'b1;
                        if (report)
                        begin
                            // a new report pushes the waiting one out, not last
                            pend_valid_reg <= 1'b1;
                            pend_span_reg  <= span;
                            pend_at_reg    <= at_pos;
                            pend_p_reg     <= ex_p_reg;
                        end
                    end

                    if (pass_done)
                    begin
                        rd_p_reg <= CW'(1);
                        if (state_reg == ST_CMP)
                        begin
                            hist_reg <= MAX_PERIOD'({hist_reg, bit_reg});
                            state_reg <= eos_reg ? ST_FLUSH : ST_FIN;
                        end
                        else
                        begin
                            hist_reg    <= '0;
                            pos_reg     <= '0;
                            cnt_vld_reg <= '0;
                            state_reg   <= ST_FIN;
                        end
                    end
                end

                ST_FIN:
                begin
                    if (!pend_valid_reg)
                        state_reg <= ST_IDLE;
                    else if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef NO_ASSERTIONS
    // nothing of the previous bit may still be in flight when a new one is taken
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (!pend_valid_reg && !ex_valid_reg))
        else $error("item_ready with work still pending");

    // the shared unit only ever works on an active period
    a_ex_range: assert property (@(posedge clk) disable iff (!rst_n)
        ex_valid_reg |-> ((ex_p_reg != '0) && (ex_p_reg <= active_reg)))
        else $error("period out of active range");

    // after the flush walk the stream state is back at reset
    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && eos_reg) |-> (pos_reg == '0 && cnt_vld_reg == '0))
        else $error("stream state not cleared after end of stream");

    // the last beat of an item only leaves from the finish step
    a_last_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_reg.last_of_item |-> $past(state_reg == ST_FIN))
        else $error("last_of_item set outside finish step");
`endif

endmodule
